// ===== src/ptrs_pkg.sv =====
`timescale 1ns / 1ps
package ptrs_pkg;
   localparam int SlotCountDefault = 16;
   localparam int MaskBits = 16;

   localparam logic CMD_REGISTER = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_INVALID_SLOT = 2'd1;
   localparam logic [1:0] ST_OCCUPIED = 2'd2;
   localparam logic [1:0] ST_STOPPED = 2'd3;

   typedef struct packed {
      logic        command;
      logic [7:0]  slot_index;
      logic [31:0] start_delay;
      logic [31:0] period;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] fired_mask;
   } rsp_word_type;
endpackage

// ===== src/ptrs_ram.sv =====
`timescale 1ns / 1ps
module ptrs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== src/ptrs_mod64.sv =====
`timescale 1ns / 1ps
// Restoring remainder of a 64-bit dividend by a 32-bit divisor, one bit a cycle.
module ptrs_mod64 (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic        is_zero
);
   logic [63:0] shift_ff, shift_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] div_ff, div_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      trial    = {rem_ff[31:0], shift_ff[63]};
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
         cnt_in   = 7'd0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         shift_in = {shift_ff[62:0], 1'b0};
         if (trial >= {1'b0, div_ff}) rem_in = trial - {1'b0, div_ff};
         else rem_in = trial;
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      cnt_ff   <= cnt_in;
   end

   assign done    = done_ff;
   assign is_zero = (rem_ff == '0);
endmodule

// ===== src/periodic_task_release_scheduler.sv =====
`timescale 1ns / 1ps
// Periodic task release scheduler.
// Command channel: pulse req_start with req_word while busy is low. A register
// word stores delay and period in a free slot; a running tick walks all slots.
// Each command yields exactly one rsp_word, shown for one cycle with rsp_valid;
// the receiver cannot stall it.
// A register word answers with rsp_valid in the cycle after the accepting
// edge. A tick walks each slot through S_READ, S_EVAL and S_NEXT, with S_MOD
// added for a valid slot with zero delay and nonzero period, where it waits
// on the bit-serial remainder unit.
// A stopped tick answers likewise. One command is worked at a time.
// csr_wr_en/csr_wr_data write run_enable at any idle time.
// Reset: slots all empty, tick count 1, run_enable 0. Slot data sit in one
// RAM with per-slot valid flops, so no clearing pass is needed.
module periodic_task_release_scheduler
   import ptrs_pkg::*;
#(
   parameter int SLOT_COUNT = SlotCountDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_start,
   input  req_word_type req_word,
   output logic         busy,
   output logic         rsp_valid,
   output rsp_word_type rsp_word,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);
   localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CW = $clog2(SLOT_COUNT + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_EVAL, S_MOD, S_NEXT
   } state_type;

   state_type    state_ff;
   logic         run_ff;
   logic [SLOT_COUNT-1:0] valid_ff;
   logic [63:0]  tick_ff;
   logic [CW-1:0] slot_ff;
   logic [15:0]  mask_ff;
   logic         busy_ff, rvalid_ff;
   rsp_word_type rsp_ff;

   logic         wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [63:0]  wr_data, rd_data;
   logic         mod_start, mod_done, mod_zero;
   logic         in_range;

   assign rd_addr  = slot_ff[AW-1:0];
   assign in_range = ({24'd0, req_word.slot_index} < 32'(SLOT_COUNT));

   ptrs_ram #(.WIDTH(64), .DEPTH(1 << AW)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   ptrs_mod64 u_mod (
      .clock(clock), .reset(reset), .start(mod_start), .dividend(tick_ff),
      .divisor(rd_data[31:0]), .done(mod_done), .is_zero(mod_zero)
   );

   // rd_data: [63:32] delay, [31:0] period
   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = rd_addr;
      wr_data   = {rd_data[63:32] - 32'd1, rd_data[31:0]};
      mod_start = 1'b0;
      if (state_ff == S_IDLE && req_start && req_word.command == CMD_REGISTER
          && in_range && !valid_ff[req_word.slot_index[AW-1:0]]) begin
         wr_en   = 1'b1;
         wr_addr = req_word.slot_index[AW-1:0];
         wr_data = {req_word.start_delay, req_word.period};
      end else if (state_ff == S_EVAL && valid_ff[rd_addr]) begin
         if (rd_data[63:32] != 32'd0) wr_en = 1'b1;
         else if (rd_data[31:0] != 32'd0) mod_start = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         run_ff    <= 1'b0;
         valid_ff  <= '0;
         tick_ff   <= 64'd1;
         busy_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) run_ff <= csr_wr_data;
         case (state_ff)
            S_IDLE: begin
               // a running tick answers only after the walk
               rvalid_ff <= req_start && !(req_word.command == CMD_TICK && run_ff);
               if (req_start) begin
                  rsp_ff.fired_mask <= '0;
                  if (req_word.command == CMD_REGISTER) begin
                     if (!in_range) rsp_ff.status <= ST_INVALID_SLOT;
                     else if (valid_ff[req_word.slot_index[AW-1:0]])
                        rsp_ff.status <= ST_OCCUPIED;
                     else begin
                        rsp_ff.status <= ST_OK;
                        valid_ff[req_word.slot_index[AW-1:0]] <= 1'b1;
                     end
                  end else if (!run_ff) begin
                     rsp_ff.status <= ST_STOPPED;
                  end else begin
                     busy_ff   <= 1'b1;
                     slot_ff   <= '0;
                     mask_ff   <= '0;
                     state_ff  <= S_READ;
                  end
               end
            end
            S_READ: begin
               rvalid_ff <= 1'b0;
               state_ff  <= S_EVAL;
            end
            S_EVAL: begin
               rvalid_ff <= 1'b0;
               if (mod_start) state_ff <= S_MOD;
               else state_ff <= S_NEXT;
            end
            S_MOD: begin
               rvalid_ff <= 1'b0;
               if (mod_done) begin
                  if (mod_zero && 32'(slot_ff) < 32'(MaskBits))
                     mask_ff[4'(slot_ff)] <= 1'b1;
                  state_ff <= S_NEXT;
               end
            end
            S_NEXT: begin
               if (slot_ff == CW'(SLOT_COUNT - 1)) begin
                  tick_ff   <= tick_ff + 64'd1;
                  rvalid_ff <= 1'b1;
                  rsp_ff.status     <= ST_OK;
                  rsp_ff.fired_mask <= mask_ff;
                  busy_ff  <= 1'b0;
                  state_ff <= S_IDLE;
               end else begin
                  rvalid_ff <= 1'b0;
                  slot_ff  <= slot_ff + CW'(1);
                  state_ff <= S_READ;
               end
            end
            default: begin
               rvalid_ff <= 1'b0;
               state_ff  <= S_IDLE;
            end
         endcase
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rvalid_ff;
   assign rsp_word  = rsp_ff;

   a_busy_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !busy_ff) else $error("busy outside walk");
   a_no_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rvalid_ff) else $error("response during walk");
   a_tick_inc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && $past(state_ff) == S_IDLE && !$past(reset))
      |-> $stable(tick_ff)) else $error("tick count moved while idle");
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import ptrs_pkg::*;

   localparam int NumSlots = 16;
   localparam int RandomWords = 515;

   logic         clock;
   logic         reset;
   logic         req_start;
   req_word_type req_word;
   logic         busy;
   logic         rsp_valid;
   rsp_word_type rsp_word;
   logic         csr_wr_en;
   logic         csr_wr_data;

   periodic_task_release_scheduler #(.SLOT_COUNT(NumSlots)) i_dut (
      .clock(clock),
      .reset(reset),
      .req_start(req_start),
      .req_word(req_word),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .rsp_word(rsp_word),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // scheduler shadow state
   logic        sched_run;
   logic        sched_valid [NumSlots];
   logic [31:0] sched_delay [NumSlots];
   logic [31:0] sched_period [NumSlots];
   logic [63:0] sched_ticks;

   rsp_word_type pending_rsp [$];
   int           error_count;
   int           sender_idle_pct;

   typedef struct {
      req_word_type w;
      logic         has_exp;
      rsp_word_type exp;
   } stim_row_type;

   stim_row_type stim_rows [$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic rsp_word_type predict_schedule(input req_word_type w);
      rsp_word_type r;
      logic [15:0]  fired;
      fired = '0;
      r.fired_mask = '0;
      if (w.command == CMD_REGISTER) begin
         if (w.slot_index >= NumSlots) begin
            r.status = ST_INVALID_SLOT;
         end else if (sched_valid[w.slot_index]) begin
            r.status = ST_OCCUPIED;
         end else begin
            sched_valid[w.slot_index] = 1'b1;
            sched_delay[w.slot_index] = w.start_delay;
            sched_period[w.slot_index] = w.period;
            r.status = ST_OK;
         end
      end else if (!sched_run) begin
         r.status = ST_STOPPED;
      end else begin
         for (int i = 0; i < NumSlots; i++) begin
            if (sched_valid[i]) begin
               if (sched_delay[i] != 0)
                  sched_delay[i] = sched_delay[i] - 1;
               else if (sched_period[i] != 0 &&
                        (sched_ticks % {32'd0, sched_period[i]}) == 0)
                  fired[i] = 1'b1;
            end
         end
         sched_ticks = sched_ticks + 1;
         r.status = ST_OK;
         r.fired_mask = fired;
      end
      return r;
   endfunction

   // results cannot be stalled; check every strobe
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected word", int'(rsp_word), 0);
         end else begin
            if (rsp_word.status !== pending_rsp[0].status)
               report_mismatch("status", int'(rsp_word.status),
                               int'(pending_rsp[0].status));
            if (rsp_word.fired_mask !== pending_rsp[0].fired_mask)
               report_mismatch("fired_mask", int'(rsp_word.fired_mask),
                               int'(pending_rsp[0].fired_mask));
            void'(pending_rsp.pop_front());
         end
      end
   end

   task automatic send_word(input req_word_type w, input logic has_exp,
                            input rsp_word_type exp);
      rsp_word_type p;
      logic         taken;
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_start <= 1'b0;
         @(posedge clock);
      end
      req_start <= 1'b1;
      req_word <= w;
      // busy is steady from the falling edge to the next rising edge
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      // accepted at this edge
      p = predict_schedule(w);
      if (has_exp && p !== exp)
         report_mismatch("table entry vs predictor", int'(p), int'(exp));
      pending_rsp.push_back(p);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_start <= 1'b0;
      while (pending_rsp.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (1200) @(posedge clock);
   endtask

   task automatic write_run(input logic v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sched_run = v;
      @(posedge clock);
   endtask

   function automatic req_word_type make_word(input logic c, input logic [7:0] s,
                                              input logic [31:0] d, input logic [31:0] p);
      req_word_type w;
      w.command = c;
      w.slot_index = s;
      w.start_delay = d;
      w.period = p;
      return w;
   endfunction

   function automatic rsp_word_type make_rsp(input logic [1:0] s, input logic [15:0] m);
      rsp_word_type r;
      r.status = s;
      r.fired_mask = m;
      return r;
   endfunction

   task automatic add_row(input req_word_type w, input logic h, input rsp_word_type e);
      stim_row_type row;
      row.w = w;
      row.has_exp = h;
      row.exp = e;
      stim_rows.push_back(row);
   endtask

   function automatic req_word_type random_word();
      req_word_type w;
      w.command = ($urandom_range(99, 0) < 70) ? CMD_TICK : CMD_REGISTER;
      w.slot_index = ($urandom_range(9, 0) == 0) ? 8'($urandom) : 8'($urandom_range(15, 0));
      case ($urandom_range(3, 0))
         0: w.start_delay = 32'($urandom);
         default: w.start_delay = 32'($urandom_range(6, 0));
      endcase
      case ($urandom_range(4, 0))
         0: w.period = 32'($urandom);
         1: w.period = '0;
         default: w.period = 32'($urandom_range(5, 1));
      endcase
      return w;
   endfunction

   initial begin
      rsp_word_type none;
      none = '0;
      error_count = 0;
      sender_idle_pct = 0;
      reset = 1'b1;
      req_start = 1'b0;
      req_word = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      sched_run = 1'b0;
      sched_ticks = 64'd1;
      for (int i = 0; i < NumSlots; i++) begin
         sched_valid[i] = 1'b0;
         sched_delay[i] = '0;
         sched_period[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: stopped tick, out of range, occupied, extremes, zero period
      add_row(make_word(CMD_TICK, 8'd0, '1, '1), 1'b1, make_rsp(ST_STOPPED, 16'h0));
      add_row(make_word(CMD_REGISTER, 8'd255, '1, '1), 1'b1, make_rsp(ST_INVALID_SLOT, 16'h0));
      add_row(make_word(CMD_REGISTER, 8'd16, 32'd0, 32'd1), 1'b1,
              make_rsp(ST_INVALID_SLOT, 16'h0));
      add_row(make_word(CMD_REGISTER, 8'd0, 32'd0, 32'd1), 1'b1, make_rsp(ST_OK, 16'h0));
      add_row(make_word(CMD_REGISTER, 8'd0, 32'd3, 32'd2), 1'b1, make_rsp(ST_OCCUPIED, 16'h0));
      add_row(make_word(CMD_REGISTER, 8'd15, 32'd0, '1), 1'b1, make_rsp(ST_OK, 16'h0));
      add_row(make_word(CMD_REGISTER, 8'd7, 32'd2, 32'd0), 1'b1, make_rsp(ST_OK, 16'h0));
      add_row(make_word(CMD_REGISTER, 8'd3, '1, 32'd1), 1'b1, make_rsp(ST_OK, 16'h0));
      add_row(make_word(CMD_REGISTER, 8'd1, 32'd1, 32'd2), 1'b1, make_rsp(ST_OK, 16'h0));
      add_row(make_word(CMD_REGISTER, 8'd2, 32'd0, 32'h8000_0000), 1'b1,
              make_rsp(ST_OK, 16'h0));
      add_row(make_word(CMD_TICK, 8'd0, '0, '0), 1'b1, make_rsp(ST_STOPPED, 16'h0));
      foreach (stim_rows[k]) send_word(stim_rows[k].w, stim_rows[k].has_exp, stim_rows[k].exp);
      stim_rows.delete();
      write_run(1'b1);
      // first running tick: tick count 1, slot 0 fires
      add_row(make_word(CMD_TICK, '1, '1, '1), 1'b1, make_rsp(ST_OK, 16'h0001));
      for (int k = 0; k < 8; k++) add_row(make_word(CMD_TICK, 8'($urandom), '0, '0), 1'b0, none);
      add_row(make_word(CMD_REGISTER, 8'd4, 32'd1, 32'd1), 1'b0, none);
      add_row(make_word(CMD_TICK, 8'd0, '0, '0), 1'b0, none);
      add_row(make_word(CMD_TICK, 8'd0, '0, '0), 1'b0, none);
      foreach (stim_rows[k]) send_word(stim_rows[k].w, stim_rows[k].has_exp, stim_rows[k].exp);

      // random phases; table refills need reset, so slots mostly stay occupied
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: sender_idle_pct = 0;
            1: sender_idle_pct = 68;
            2: sender_idle_pct = 0;
            3: sender_idle_pct = 68;
            default: sender_idle_pct = 10;
         endcase
         if (ph == 2) write_run(1'b0);
         if (ph == 3) write_run(1'b1);
         for (int k = 0; k < RandomWords / 5; k++) begin
            if (k == 50) drain();
            send_word(random_word(), 1'b0, none);
         end
      end

      drain();
      if (pending_rsp.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
